[sv/assert_macros.svh]
// assertion macros used by the checker file
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked, reset-qualified property wrapper
`define C8IE_PROP(p) @(posedge clk) disable iff (!rst_n) (p)

// labeled concurrent assertion reporting through $error
`define C8IE_ASSERT(lbl, p, msg) \
    lbl: assert property (`C8IE_PROP(p)) else $error(msg);

`endif

[sv/c8ie_pkg.sv]
// shared constants, state codes and helper functions of the chip8 executor
// no dependencies
package c8ie_pkg;

    localparam int MEM_BYTES       = 4096;
    localparam int ADDR_W          = 12;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int SCREEN_W        = 64;
    localparam int SCREEN_H        = 32;
    localparam int ROW_W           = 5;
    localparam int FONT_LEN        = 80;

    localparam logic [11:0] PROG_START = 12'h200;
    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam logic [7:0]  DELAY_INIT = 8'd60;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_EXEC  = 2'd1,
        OP_ROW   = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [18:0] {
        S_INIT = 19'd1 << 0,
        S_IDLE = 19'd1 << 1,
        S_ROW  = 19'd1 << 2,
        S_F1   = 19'd1 << 3,
        S_F2   = 19'd1 << 4,
        S_RX   = 19'd1 << 5,
        S_RY   = 19'd1 << 6,
        S_EXEC = 19'd1 << 7,
        S_FLAG = 19'd1 << 8,
        S_RET  = 19'd1 << 9,
        S_CLR  = 19'd1 << 10,
        S_DRD  = 19'd1 << 11,
        S_DWR  = 19'd1 << 12,
        S_BCD  = 19'd1 << 13,
        S_STR  = 19'd1 << 14,
        S_STW  = 19'd1 << 15,
        S_LDR  = 19'd1 << 16,
        S_LDW  = 19'd1 << 17,
        S_DONE = 19'd1 << 18
    } state_t;

    localparam logic [7:0] GLYPHS [0:FONT_LEN-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [11:0] a);
        logic [11:0] off;
        off = a - FONT_BASE;
        if (off < 12'(FONT_LEN))
            return GLYPHS[off[6:0]];
        return 8'h00;
    endfunction

    function automatic logic [3:0] lowest_key(input logic [15:0] k);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 15; i >= 0; i--)
            if (k[i])
                r = 4'(i);
        return r;
    endfunction

endpackage

[sv/c8ie_if.sv]
// input and result channel interfaces of the chip8 executor
// no dependencies
interface c8ie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] address;
    logic [7:0]  write_data;
    logic [4:0]  row_select;
    logic [15:0] keys_down;
    logic [7:0]  random_byte;

    modport source (output valid, opcode, address, write_data, row_select,
                    keys_down, random_byte, input ready);
    modport sink   (input valid, opcode, address, write_data, row_select,
                    keys_down, random_byte, output ready);
endinterface

interface c8ie_out_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [11:0] program_counter;
    logic [15:0] fetched_word;
    logic        screen_changed;
    logic        sound_on;
    logic [63:0] row_pixels;

    modport source (output valid, status, program_counter, fetched_word,
                    screen_changed, sound_on, row_pixels, input ready);
    modport sink   (input valid, status, program_counter, fetched_word,
                    screen_changed, sound_on, row_pixels, output ready);
endinterface

[sv/c8ie_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module c8ie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

[sv/chip8_instruction_executor.sv]
// chip8 executor top: sequencer around memory, register, stack and frame rams
// depends on c8ie_pkg, c8ie_if, c8ie_ram
//
// usage:
//   in_ch carries one beat per item: write a memory byte, execute one
//   instruction, read one display row, or none; out_ch returns one beat per item.
//   items are handled one at a time; in_ch.ready is high only when idle.
//   a write goes to memory on accept, a row read reads the frame row, and
//   an instruction steps through fetch (F1, F2), register reads (RX, RY)
//   and execute; 8XY4..8XYE and DXYN then write VF, 00EE reads the stack,
//   FX33 writes three digits, 00E0 clears each row, DXYN reads and writes
//   each sprite row, and FX55/FX65 copy one register at a time.
//   after reset a sweep over every memory address loads the font, clears memory,
//   registers, stack and frame; in_ch.ready stays low during it.
//   the result sits in an output register; a stalled receiver holds it there
//   while the next item is already being worked on, and the sequencer waits
//   at its last step until that register is free.
module chip8_instruction_executor
    import c8ie_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    c8ie_in_if.sink           in_ch,
    c8ie_out_if.source        out_ch
);

    localparam int SPW = $clog2(STACK_DEPTH);

    state_t          state_reg, state_next;
    logic [11:0]     cnt_reg, cnt_next;
    logic [11:0]     pc_reg, pc_next;
    logic [15:0]     idx_reg, idx_next;
    logic [SPW-1:0]  sp_reg, sp_next;
    logic [7:0]      dly_reg, dly_next;
    logic [7:0]      snd_reg, snd_next;
    logic            halt_reg, halt_next;
    logic [15:0]     word_reg, word_next;
    logic [7:0]      vx_reg, vx_next;
    logic [7:0]      vy_reg, vy_next;
    logic            flag_reg, flag_next;
    logic            tick_reg, tick_next;
    logic            drew_reg, drew_next;
    logic [63:0]     row_reg, row_next;
    logic [15:0]     keys_reg, keys_next;
    logic [7:0]      rnd_reg, rnd_next;
    logic            oval_reg, oval_next;
    logic            ostat_reg, ostat_next;
    logic [11:0]     opc_reg, opc_next;
    logic [15:0]     oword_reg, oword_next;
    logic            odrew_reg, odrew_next;
    logic            osnd_reg, osnd_next;
    logic [63:0]     orow_reg, orow_next;

    logic            mem_we;
    logic [11:0]     mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata, mem_rdata;
    logic            reg_we;
    logic [3:0]      reg_waddr, reg_raddr;
    logic [7:0]      reg_wdata, reg_rdata;
    logic            stk_we;
    logic [SPW-1:0]  stk_waddr, stk_raddr;
    logic [11:0]     stk_wdata, stk_rdata;
    logic            frm_we;
    logic [4:0]      frm_waddr, frm_raddr;
    logic [63:0]     frm_wdata, frm_rdata;

    logic [3:0]      w_x, w_y, w_n;
    logic [7:0]      w_nn;
    logic [11:0]     w_nnn;
    logic [SPW-1:0]  sp_inc, sp_dec;
    logic [11:0]     idx_addr;
    logic [5:0]      y_cur;
    logic [63:0]     sprite_bits;
    logic [1:0]      hund;
    logic [7:0]      rem;
    logic [14:0]     tens_prod;
    logic [3:0]      tens;
    logic [7:0]      ones;
    logic [8:0]      sum9;
    logic            in_acc;
    logic            out_free;
    logic [7:0]      snd_after;

    c8ie_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
        .clk(clk), .we(reg_we), .waddr(reg_waddr), .wdata(reg_wdata),
        .raddr(reg_raddr), .rdata(reg_rdata)
    );

    c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata)
    );

    c8ie_ram #(.WIDTH(SCREEN_W), .DEPTH(SCREEN_H)) u_frame (
        .clk(clk), .we(frm_we), .waddr(frm_waddr), .wdata(frm_wdata),
        .raddr(frm_raddr), .rdata(frm_rdata)
    );

    assign w_x   = word_reg[11:8];
    assign w_y   = word_reg[7:4];
    assign w_n   = word_reg[3:0];
    assign w_nn  = word_reg[7:0];
    assign w_nnn = word_reg[11:0];

    assign sp_inc = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    assign idx_addr    = idx_reg[11:0] + cnt_reg;
    assign y_cur       = {1'b0, vy_reg[4:0]} + {2'b00, cnt_reg[3:0]};
    assign sprite_bits = {mem_rdata, 56'd0} >> vx_reg[5:0];

    // decimal digits of vx
    assign hund      = (vx_reg >= 8'd200) ? 2'd2 : ((vx_reg >= 8'd100) ? 2'd1 : 2'd0);
    assign rem       = vx_reg - 8'(hund) * 8'd100;
    assign tens_prod = 15'(rem) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign ones      = rem - 8'(tens) * 8'd10;
    assign sum9      = {1'b0, vx_reg} + {1'b0, vy_reg};

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !oval_reg || out_ch.ready;
    assign snd_after   = (tick_reg && snd_reg != 8'd0) ? snd_reg - 8'd1 : snd_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        sp_next    = sp_reg;
        dly_next   = dly_reg;
        snd_next   = snd_reg;
        halt_next  = halt_reg;
        word_next  = word_reg;
        vx_next    = vx_reg;
        vy_next    = vy_reg;
        flag_next  = flag_reg;
        tick_next  = tick_reg;
        drew_next  = drew_reg;
        row_next   = row_reg;
        keys_next  = keys_reg;
        rnd_next   = rnd_reg;
        ostat_next = ostat_reg;
        opc_next   = opc_reg;
        oword_next = oword_reg;
        odrew_next = odrew_reg;
        osnd_next  = osnd_reg;
        orow_next  = orow_reg;
        oval_next  = oval_reg && !out_ch.ready;

        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = 8'd0;
        mem_raddr = idx_addr;
        reg_we    = 1'b0;
        reg_waddr = w_x;
        reg_wdata = 8'd0;
        reg_raddr = w_x;
        stk_we    = 1'b0;
        stk_waddr = sp_reg;
        stk_wdata = pc_reg;
        stk_raddr = sp_dec;
        frm_we    = 1'b0;
        frm_waddr = y_cur[4:0];
        frm_wdata = 64'd0;
        frm_raddr = y_cur[4:0];

        unique case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                mem_wdata = font_byte(cnt_reg);
                reg_we    = (cnt_reg < 12'd16);
                reg_waddr = cnt_reg[3:0];
                stk_we    = (cnt_reg < 12'(STACK_DEPTH));
                stk_waddr = cnt_reg[SPW-1:0];
                stk_wdata = 12'd0;
                frm_we    = (cnt_reg < 12'(SCREEN_H));
                frm_waddr = cnt_reg[4:0];
                cnt_next  = cnt_reg + 12'd1;
                if (cnt_reg == 12'(MEM_BYTES - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_acc)
                begin
                    keys_next = in_ch.keys_down;
                    rnd_next  = in_ch.random_byte;
                    word_next = 16'd0;
                    row_next  = 64'd0;
                    drew_next = 1'b0;
                    tick_next = 1'b0;
                    cnt_next  = 12'd0;
                    state_next = S_DONE;
                    if (in_ch.opcode == OP_WRITE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = in_ch.address;
                        mem_wdata = in_ch.write_data;
                    end
                    else if (in_ch.opcode == OP_ROW)
                    begin
                        frm_raddr  = in_ch.row_select;
                        state_next = S_ROW;
                    end
                    else if (in_ch.opcode == OP_EXEC && !halt_reg)
                    begin
                        mem_raddr  = pc_reg;
                        state_next = S_F1;
                    end
                end
            end
            S_ROW:
            begin
                row_next   = frm_rdata;
                state_next = S_DONE;
            end
            S_F1:
            begin
                mem_raddr       = pc_reg + 12'd1;
                word_next[15:8] = mem_rdata;
                state_next      = S_F2;
            end
            S_F2:
            begin
                word_next[7:0] = mem_rdata;
                pc_next        = pc_reg + 12'd2;
                reg_raddr      = word_reg[11:8];
                state_next     = S_RX;
            end
            S_RX:
            begin
                vx_next    = reg_rdata;
                reg_raddr  = (word_reg[15:12] == 4'hB) ? 4'h0 : w_y;
                state_next = S_RY;
            end
            S_RY:
            begin
                vy_next    = reg_rdata;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                tick_next  = 1'b1;
                cnt_next   = 12'd0;
                state_next = S_DONE;
                unique case (word_reg[15:12])
                    4'h0:
                    begin
                        if (word_reg == 16'h00E0)
                        begin
                            drew_next  = 1'b1;
                            state_next = S_CLR;
                        end
                        else if (word_reg == 16'h00EE)
                        begin
                            sp_next    = sp_dec;
                            state_next = S_RET;
                        end
                    end
                    4'h1: pc_next = w_nnn;
                    4'h2:
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_inc;
                        pc_next = w_nnn;
                    end
                    4'h3: if (vx_reg == w_nn) pc_next = pc_reg + 12'd2;
                    4'h4: if (vx_reg != w_nn) pc_next = pc_reg + 12'd2;
                    4'h5: if (vx_reg == vy_reg) pc_next = pc_reg + 12'd2;
                    4'h9: if (vx_reg != vy_reg) pc_next = pc_reg + 12'd2;
                    4'h6:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = w_nn;
                    end
                    4'h7:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = vx_reg + w_nn;
                    end
                    4'h8:
                    begin
                        reg_we = 1'b1;
                        unique case (w_n)
                            4'h0: reg_wdata = vy_reg;
                            4'h1: reg_wdata = vx_reg | vy_reg;
                            4'h2: reg_wdata = vx_reg & vy_reg;
                            4'h3: reg_wdata = vx_reg ^ vy_reg;
                            4'h4:
                            begin
                                reg_wdata  = sum9[7:0];
                                flag_next  = sum9[8];
                                state_next = S_FLAG;
                            end
                            4'h5:
                            begin
                                reg_wdata  = vx_reg - vy_reg;
                                flag_next  = (vx_reg >= vy_reg);
                                state_next = S_FLAG;
                            end
                            4'h6:
                            begin
                                reg_wdata  = {1'b0, vx_reg[7:1]};
                                flag_next  = vx_reg[0];
                                state_next = S_FLAG;
                            end
                            4'h7:
                            begin
                                reg_wdata  = vy_reg - vx_reg;
                                flag_next  = (vy_reg >= vx_reg);
                                state_next = S_FLAG;
                            end
                            4'hE:
                            begin
                                reg_wdata  = {vx_reg[6:0], 1'b0};
                                flag_next  = vx_reg[7];
                                state_next = S_FLAG;
                            end
                            default:
                            begin
                                reg_we    = 1'b0;
                                halt_next = 1'b1;
                                tick_next = 1'b0;
                            end
                        endcase
                    end
                    4'hA: idx_next = {4'd0, w_nnn};
                    4'hB: pc_next = w_nnn + {4'd0, vy_reg};
                    4'hC:
                    begin
                        reg_we    = 1'b1;
                        reg_wdata = rnd_reg & w_nn;
                    end
                    4'hD:
                    begin
                        drew_next  = 1'b1;
                        flag_next  = 1'b0;
                        state_next = S_DRD;
                    end
                    4'hE:
                    begin
                        if (w_nn == 8'h9E)
                        begin
                            if (keys_reg[vx_reg[3:0]])
                                pc_next = pc_reg + 12'd2;
                        end
                        else if (w_nn == 8'hA1)
                        begin
                            if (!keys_reg[vx_reg[3:0]])
                                pc_next = pc_reg + 12'd2;
                        end
                        else
                        begin
                            halt_next = 1'b1;
                            tick_next = 1'b0;
                        end
                    end
                    4'hF:
                    begin
                        unique case (w_nn)
                            8'h07:
                            begin
                                reg_we    = 1'b1;
                                reg_wdata = dly_reg;
                            end
                            8'h0A:
                            begin
                                if (keys_reg == 16'd0)
                                    pc_next = pc_reg - 12'd2;
                                else
                                begin
                                    reg_we    = 1'b1;
                                    reg_wdata = {4'd0, lowest_key(keys_reg)};
                                end
                            end
                            8'h15: dly_next = vx_reg;
                            8'h18: snd_next = vx_reg;
                            8'h1E: idx_next = idx_reg + {8'd0, vx_reg};
                            8'h29: idx_next = {4'd0, FONT_BASE}
                                            + 16'(vx_reg[3:0] * 7'd5);
                            8'h33: state_next = S_BCD;
                            8'h55: state_next = S_STR;
                            8'h65: state_next = S_LDR;
                            default:
                            begin
                                halt_next = 1'b1;
                                tick_next = 1'b0;
                            end
                        endcase
                    end
                    default: ;
                endcase
            end
            S_FLAG:
            begin
                reg_we     = 1'b1;
                reg_waddr  = 4'hF;
                reg_wdata  = {7'd0, flag_reg};
                state_next = S_DONE;
            end
            S_RET:
            begin
                pc_next    = stk_rdata;
                state_next = S_DONE;
            end
            S_CLR:
            begin
                frm_we    = 1'b1;
                frm_waddr = cnt_reg[4:0];
                cnt_next  = cnt_reg + 12'd1;
                if (cnt_reg[4:0] == 5'(SCREEN_H - 1))
                    state_next = S_DONE;
            end
            S_DRD:
            begin
                if (cnt_reg[4:0] == {1'b0, w_n} || y_cur[5])
                    state_next = S_FLAG;
                else
                    state_next = S_DWR;
            end
            S_DWR:
            begin
                if ((frm_rdata & sprite_bits) != 64'd0)
                    flag_next = 1'b1;
                frm_we     = 1'b1;
                frm_wdata  = frm_rdata ^ sprite_bits;
                cnt_next   = cnt_reg + 12'd1;
                state_next = S_DRD;
            end
            S_BCD:
            begin
                mem_we = 1'b1;
                unique case (cnt_reg[1:0])
                    2'd0:    mem_wdata = {6'd0, hund};
                    2'd1:    mem_wdata = {4'd0, tens};
                    default: mem_wdata = ones;
                endcase
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg[1:0] == 2'd2)
                    state_next = S_DONE;
            end
            S_STR:
            begin
                reg_raddr  = cnt_reg[3:0];
                state_next = S_STW;
            end
            S_STW:
            begin
                mem_we     = 1'b1;
                mem_wdata  = reg_rdata;
                cnt_next   = cnt_reg + 12'd1;
                state_next = (cnt_reg[3:0] == w_x) ? S_DONE : S_STR;
            end
            S_LDR:
            begin
                state_next = S_LDW;
            end
            S_LDW:
            begin
                reg_we     = 1'b1;
                reg_waddr  = cnt_reg[3:0];
                reg_wdata  = mem_rdata;
                cnt_next   = cnt_reg + 12'd1;
                state_next = (cnt_reg[3:0] == w_x) ? S_DONE : S_LDR;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    if (tick_reg && dly_reg != 8'd0)
                        dly_next = dly_reg - 8'd1;
                    snd_next   = snd_after;
                    oval_next  = 1'b1;
                    ostat_next = halt_reg;
                    opc_next   = pc_reg;
                    oword_next = word_reg;
                    odrew_next = drew_reg;
                    osnd_next  = (snd_after != 8'd0);
                    orow_next  = row_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            pc_reg    <= PROG_START;
            idx_reg   <= '0;
            sp_reg    <= '0;
            dly_reg   <= DELAY_INIT;
            snd_reg   <= '0;
            halt_reg  <= 1'b0;
            tick_reg  <= 1'b0;
            oval_reg  <= 1'b0;
            ostat_reg <= 1'b0;
            opc_reg   <= '0;
            oword_reg <= '0;
            odrew_reg <= 1'b0;
            osnd_reg  <= 1'b0;
            orow_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
            sp_reg    <= sp_next;
            dly_reg   <= dly_next;
            snd_reg   <= snd_next;
            halt_reg  <= halt_next;
            tick_reg  <= tick_next;
            oval_reg  <= oval_next;
            ostat_reg <= ostat_next;
            opc_reg   <= opc_next;
            oword_reg <= oword_next;
            odrew_reg <= odrew_next;
            osnd_reg  <= osnd_next;
            orow_reg  <= orow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        vx_reg   <= vx_next;
        vy_reg   <= vy_next;
        flag_reg <= flag_next;
        drew_reg <= drew_next;
        row_reg  <= row_next;
        keys_reg <= keys_next;
        rnd_reg  <= rnd_next;
    end

    assign out_ch.valid           = oval_reg;
    assign out_ch.status          = ostat_reg;
    assign out_ch.program_counter = opc_reg;
    assign out_ch.fetched_word    = oword_reg;
    assign out_ch.screen_changed  = odrew_reg;
    assign out_ch.sound_on        = osnd_reg;
    assign out_ch.row_pixels      = orow_reg;

endmodule

[sv/c8ie_checker.sv]
// port-level checker of the chip8 executor, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module c8ie_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_status,
    input logic [15:0] out_fetched_word,
    input logic        out_screen_changed,
    input logic [63:0] out_row_pixels
);

    `C8IE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_fetched_word), "result beat changed while stalled")
    `C8IE_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second beat taken while busy")
    `C8IE_ASSERT(a_halt_sticky, out_valid && out_status |=> out_status, "halt status cleared")
    `C8IE_ASSERT(a_row_only, out_valid && out_row_pixels != 64'd0 |-> out_fetched_word == 16'd0 && !out_screen_changed, "row beat carries execute fields")

endmodule

bind chip8_instruction_executor c8ie_checker u_c8ie_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .out_status(out_ch.status),
    .out_fetched_word(out_ch.fetched_word),
    .out_screen_changed(out_ch.screen_changed),
    .out_row_pixels(out_ch.row_pixels)
);

[tb/sv/tb_chip8_if_note.sv]
`timescale 1ns / 1ps
// testbench constants package; the channel interfaces come from the rtl
// no dependencies
package tb_chip8_consts;
    localparam int WATCHDOG_CYCLES = 20000;
endpackage

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// testbench for chip8_instruction_executor: directed table, directed program,
// then random programs, every result checked against an in-bench interpreter model
// depends on c8ie_pkg, c8ie_if, tb_chip8_consts and the executor rtl
module tb;
    import c8ie_pkg::*;
    import tb_chip8_consts::*;

    typedef struct packed {
        logic        status;
        logic [11:0] pc;
        logic [15:0] word;
        logic        drew;
        logic        sound;
        logic [63:0] row;
    } result_t;

    typedef struct {
        op_t         op;
        logic [11:0] addr;
        logic [7:0]  data;
        logic [4:0]  rsel;
        logic [15:0] keys;
        logic [7:0]  rnd;
        logic        typed;
        result_t     want;
    } beat_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    c8ie_in_if  in_ch();
    c8ie_out_if out_ch();

    chip8_instruction_executor uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [7:0]  mem [0:4095];
    logic [7:0]  v [0:15];
    logic [11:0] stk [0:15];
    logic [3:0]  sp;
    logic [11:0] pc;
    logic [15:0] idx;
    logic [7:0]  dly, snd;
    logic [63:0] frame [0:31];
    logic        halted;

    result_t expected_q[$];
    beat_t   table_q[$];
    int      mismatches = 0;
    int      results_seen = 0;
    int      idle_cycles = 0;
    bit      quiet = 1'b0;
    bit      timed_out = 1'b0;

    function automatic void skip(input bit c);
        if (c) pc = pc + 12'd2;
    endfunction

    function automatic bit run_word(input logic [15:0] w, input logic [15:0] keys,
                                    input logic [7:0] rnd, output bit drew);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy;
        logic [11:0] nnn;
        logic [63:0] bits;
        logic [7:0]  hit;
        int          x0, y0;
        x = w[11:8]; y = w[7:4]; n = w[3:0]; nn = w[7:0]; nnn = w[11:0];
        vx = v[x]; vy = v[y];
        drew = 1'b0;
        case (w[15:12])
            4'h0:
            begin
                if (w == 16'h00E0)
                begin
                    for (int r = 0; r < 32; r++) frame[r] = '0;
                    drew = 1'b1;
                end
                else if (w == 16'h00EE)
                begin
                    sp = sp - 4'd1;
                    pc = stk[sp];
                end
            end
            4'h1: pc = nnn;
            4'h2:
            begin
                stk[sp] = pc;
                sp = sp + 4'd1;
                pc = nnn;
            end
            4'h3: skip(vx == nn);
            4'h4: skip(vx != nn);
            4'h5: skip(vx == vy);
            4'h6: v[x] = nn;
            4'h7: v[x] = vx + nn;
            4'h8:
                case (n)
                    4'h0: v[x] = vy;
                    4'h1: v[x] = vx | vy;
                    4'h2: v[x] = vx & vy;
                    4'h3: v[x] = vx ^ vy;
                    4'h4: begin v[x] = vx + vy; v[15] = {7'd0, (9'(vx) + 9'(vy)) > 9'd255}; end
                    4'h5: begin v[x] = vx - vy; v[15] = {7'd0, vx >= vy}; end
                    4'h6: begin v[x] = vx >> 1; v[15] = {7'd0, vx[0]}; end
                    4'h7: begin v[x] = vy - vx; v[15] = {7'd0, vy >= vx}; end
                    4'hE: begin v[x] = vx << 1; v[15] = {7'd0, vx[7]}; end
                    default: return 1'b0;
                endcase
            4'h9: skip(vx != vy);
            4'hA: idx = {4'd0, nnn};
            4'hB: pc = nnn + {4'd0, v[0]};
            4'hC: v[x] = rnd & nn;
            4'hD:
            begin
                x0 = vx % 64; y0 = vy % 32; hit = 8'd0;
                for (int r = 0; r < n; r++)
                begin
                    if (y0 + r >= 32) break;
                    bits = {mem[12'(idx + 16'(r))], 56'd0} >> x0;
                    if ((frame[y0 + r] & bits) != 0) hit = 8'd1;
                    frame[y0 + r] ^= bits;
                end
                v[15] = hit;
                drew = 1'b1;
            end
            4'hE:
                if (nn == 8'h9E) skip(keys[vx[3:0]]);
                else if (nn == 8'hA1) skip(!keys[vx[3:0]]);
                else return 1'b0;
            default:
                case (nn)
                    8'h07: v[x] = dly;
                    8'h0A:
                        if (keys == 0) pc = pc - 12'd2;
                        else
                        begin
                            for (int i = 15; i >= 0; i--) if (keys[i]) v[x] = 8'(i);
                        end
                    8'h15: dly = vx;
                    8'h18: snd = vx;
                    8'h1E: idx = idx + {8'd0, vx};
                    8'h29: idx = {4'd0, FONT_BASE} + 16'(vx[3:0]) * 16'd5;
                    8'h33:
                    begin
                        mem[12'(idx)] = 8'(vx / 100);
                        mem[12'(idx + 16'd1)] = 8'((vx / 10) % 10);
                        mem[12'(idx + 16'd2)] = 8'(vx % 10);
                    end
                    8'h55: for (int i = 0; i <= x; i++) mem[12'(idx + 16'(i))] = v[i];
                    8'h65: for (int i = 0; i <= x; i++) v[i] = mem[12'(idx + 16'(i))];
                    default: return 1'b0;
                endcase
        endcase
        return 1'b1;
    endfunction

    task automatic interp_reset();
        for (int a = 0; a < 4096; a++) mem[a] = 8'd0;
        for (int a = 0; a < FONT_LEN; a++) mem[FONT_BASE + a] = GLYPHS[a];
        for (int i = 0; i < 16; i++) begin v[i] = 8'd0; stk[i] = 12'd0; end
        for (int r = 0; r < 32; r++) frame[r] = '0;
        sp = 4'd0; pc = PROG_START; idx = 16'd0; dly = DELAY_INIT; snd = 8'd0;
        halted = 1'b0;
    endtask

    function automatic result_t interp_step(input beat_t b);
        result_t r;
        bit      drew;
        drew = 1'b0;
        r = '0;
        if (b.op == OP_WRITE) mem[b.addr] = b.data;
        else if (b.op == OP_ROW) r.row = frame[b.rsel];
        else if (b.op == OP_EXEC && !halted)
        begin
            r.word = {mem[pc], mem[pc + 12'd1]};
            pc = pc + 12'd2;
            if (run_word(r.word, b.keys, b.rnd, drew))
            begin
                if (dly != 0) dly--;
                if (snd != 0) snd--;
            end
            else halted = 1'b1;
        end
        r.status = halted; r.pc = pc; r.drew = drew; r.sound = snd != 0;
        return r;
    endfunction

    function automatic beat_t mk(input op_t op, input logic [11:0] a, input logic [7:0] d);
        beat_t b;
        b.op = op; b.addr = a; b.data = d;
        b.rsel = 5'($urandom); b.keys = 16'($urandom); b.rnd = 8'($urandom);
        b.typed = 1'b0; b.want = '0;
        return b;
    endfunction

    task automatic send(input beat_t b);
        result_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        r = interp_step(b);
        if (b.typed && r != b.want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row differs from model: want %h model %h", b.want, r);
        end
        expected_q.push_back(r);
        in_ch.valid <= 1'b1;
        in_ch.opcode <= b.op; in_ch.address <= b.addr; in_ch.write_data <= b.data;
        in_ch.row_select <= b.rsel; in_ch.keys_down <= b.keys; in_ch.random_byte <= b.rnd;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
    endtask

    // drop valid and wait until every expected result is back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
    endtask

    task automatic load_word(input logic [11:0] a, input logic [15:0] w);
        send(mk(OP_WRITE, a, w[15:8]));
        send(mk(OP_WRITE, a + 12'd1, w[7:0]));
    endtask

    function automatic logic [15:0] rand_word();
        logic [15:0] w;
        w = 16'($urandom);
        case ($urandom_range(0, 9))
            0: w = 16'h00E0;
            1: w = {w[15:12] | 4'h8, w[11:4], 4'($urandom_range(0, 7))};
            2: w = {4'hD, w[11:4], 4'($urandom_range(0, 15))};
            3: w = {4'hF, w[11:8], 8'h33};
            4: w = {4'hF, w[11:8], $urandom_range(0, 1) ? 8'h55 : 8'h65};
            5: w = {4'hE, w[11:8], $urandom_range(0, 1) ? 8'h9E : 8'hA1};
            6: w = {4'hF, w[11:8], 8'h1E};
            7: w = {4'h6, w[11:0]};
            default: if (w[15:12] == 4'hF) w[7:0] = 8'h29;
        endcase
        if (w[15:12] inside {4'h1, 4'h2, 4'hB}) w[11:0] = 12'h200 | 12'($urandom_range(0, 63) * 2);
        return w;
    endfunction

    always @(posedge clk)
    begin
        if (out_ch.valid && out_ch.ready)
        begin
            result_t got;
            got = {out_ch.status, out_ch.program_counter, out_ch.fetched_word,
                   out_ch.screen_changed, out_ch.sound_on, out_ch.row_pixels};
            results_seen++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("result beat with nothing expected: %h", got);
            end
            else
            begin
                result_t want;
                want = expected_q.pop_front();
                if (got != want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: st %b/%b pc %h/%h word %h/%h drew %b/%b snd %b/%b row %h/%h",
                                 want.status, got.status, want.pc, got.pc, want.word, got.word,
                                 want.drew, got.drew, want.sound, got.sound, want.row, got.row);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else if (quiet) out_ch.ready <= 1'b1;
        else if ($urandom_range(0, 15) == 0) out_ch.ready <= 1'b0;
        else if (!out_ch.ready && $urandom_range(0, 3) != 0) out_ch.ready <= 1'b0;
        else out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_CYCLES && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired, %0d results outstanding", expected_q.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    initial
    begin
        beat_t       b;
        logic [15:0] w;
        in_ch.valid = 1'b0; in_ch.opcode = OP_NONE; in_ch.address = '0; in_ch.write_data = '0;
        in_ch.row_select = '0; in_ch.keys_down = '0; in_ch.random_byte = '0;
        interp_reset();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        b = mk(OP_ROW, 12'd0, 8'd0); b.rsel = 5'd31; b.typed = 1'b1;
        b.want = '{1'b0, PROG_START, 16'd0, 1'b0, 1'b0, 64'd0}; table_q.push_back(b);
        b = mk(OP_NONE, 12'hFFF, 8'hFF); b.typed = 1'b1;
        b.want = '{1'b0, PROG_START, 16'd0, 1'b0, 1'b0, 64'd0}; table_q.push_back(b);
        b = mk(OP_WRITE, 12'hFFF, 8'hFF); b.typed = 1'b1;
        b.want = '{1'b0, PROG_START, 16'd0, 1'b0, 1'b0, 64'd0}; table_q.push_back(b);
        b = mk(OP_WRITE, 12'h000, 8'h00); table_q.push_back(b);
        foreach (table_q[i]) send(table_q[i]);

        // directed program: sprites, clip, flags, stack wrap, key wait, bcd
        begin
            logic [15:0] prog [$];
            prog = '{16'h00E0, 16'h603F, 16'h611F, 16'hF029, 16'hD015, 16'hD015, 16'h62FF,
                     16'h6301, 16'h8234, 16'h8235, 16'h8237, 16'h826E, 16'h8236, 16'hF20A,
                     16'hF233, 16'hF355, 16'hFF65, 16'hE39E, 16'hE3A1, 16'hFF18, 16'hC5FF,
                     16'h00EE, 16'h0123, 16'h5FFF};
            foreach (prog[i]) load_word(12'h200 + 12'(2 * i), prog[i]);
            load_word(12'h000, 16'h1200);
            for (int i = 0; i < 26; i++)
            begin
                b = mk(OP_EXEC, 12'd0, 8'd0);
                if (i == 13) b.keys = 16'd0;
                send(b);
            end
            for (int r = 0; r < 32; r++)
            begin
                b = mk(OP_ROW, 12'd0, 8'd0); b.rsel = 5'(r); send(b);
            end
        end
        drain();

        // random programs; re-reset of the model is not possible, so avoid a halt by
        // keeping only known opcodes in random programs
        for (int blk = 0; blk < 30 && !halted; blk++)
        begin
            int len;
            len = $urandom_range(4, 16);
            for (int i = 0; i < len; i++)
            begin
                w = rand_word();
                if (w[15:12] == 4'h8 && !(w[3:0] inside {[0:7], 4'hE})) w[3:0] = 4'h4;
                if (w[15:12] == 4'hE) w[7:0] = w[0] ? 8'h9E : 8'hA1;
                if (w[15:12] == 4'hF && !(w[7:0] inside {8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E,
                    8'h29, 8'h33, 8'h55, 8'h65})) w[7:0] = 8'h07;
                if (w[15:12] == 4'hF && w[7:0] inside {8'h33, 8'h55}) w[15:0] = 16'hA300 | w[11:0] & 16'h0FF;
                load_word(12'h200 + 12'(2 * i), w);
            end
            load_word(12'h200 + 12'(2 * len), 16'h1200);
            send(mk(OP_WRITE, 12'($urandom), 8'($urandom)));
            for (int i = 0; i < 30; i++)
            begin
                b = mk(OP_EXEC, 12'd0, 8'd0);
                if ($urandom_range(0, 3) == 0) b.keys = 16'd0;
                if (blk == 29) quiet = 1'b1;
                send(b);
            end
            b = mk(OP_ROW, 12'd0, 8'd0); send(b);
            if (blk == 20) drain();
            if (pc[11:9] != 3'b001 || pc > 12'h2FE)
            begin
                send(mk(OP_WRITE, pc, 8'h12));
                send(mk(OP_WRITE, pc + 12'd1, 8'h00));
                send(mk(OP_EXEC, 12'd0, 8'd0));
            end
        end
        // force a halt at the end and check halted behavior
        load_word(pc, 16'hE000);
        for (int i = 0; i < 4; i++) send(mk(OP_EXEC, 12'd0, 8'd0));
        send(mk(OP_ROW, 12'd0, 8'd0));

        drain();
        repeat (50) @(posedge clk);
        $display("covered writes, row reads, directed opcodes and random programs: %0d results",
                 results_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end
endmodule
